### sv/ole_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the ordered list engine.
// Used by the top level, the element store and the port checker. No dependencies.
package ole_pkg;

	localparam int VALUE_W          = 32;
	localparam int POS_W            = 7;
	localparam int COUNT_W          = 7;
	localparam int DEFAULT_CAPACITY = 64;

	typedef enum logic [2:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_FIND       = 3'd4,
		OP_INSERT     = 3'd5,
		OP_ERASE      = 3'd6
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_EMPTY   = 2'd1,
		ST_FULL    = 2'd2,
		ST_BAD_POS = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_POP,
		S_WALK,
		S_DRAIN,
		S_PLACE,
		S_DONE
	} fsm_t;

	typedef struct packed {
		opcode_t                    opcode;
		logic signed [VALUE_W-1:0]  value;
		logic        [POS_W-1:0]    position;
	} cmd_t;

	typedef struct packed {
		status_t                    status;
		logic signed [VALUE_W-1:0]  popped_value;
		logic                       found;
		logic        [COUNT_W-1:0]  removed_count;
		logic        [COUNT_W-1:0]  element_count;
	} rsp_t;

endpackage

### sv/ole_store.sv
`timescale 1ns / 1ps
// Element store: a ring of CAPACITY words with one write and one registered read port.
// Offsets are relative to the ring head and wrap at CAPACITY. Depends on ole_pkg.
module ole_store
	import ole_pkg::*;
#(
	parameter int CAPACITY = DEFAULT_CAPACITY,
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
	input  logic               clk,
	input  logic [AW-1:0]      base,
	input  logic               rd_en,
	input  logic [AW-1:0]      rd_off,
	output logic [VALUE_W-1:0] rd_data,
	input  logic               wr_en,
	input  logic [AW-1:0]      wr_off,
	input  logic [VALUE_W-1:0] wr_data
);

	logic [VALUE_W-1:0] mem [CAPACITY];
	logic [AW-1:0]      rd_addr;
	logic [AW-1:0]      wr_addr;

	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
		logic [AW:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		if (sum >= (AW+1)'(CAPACITY)) begin
			sum = sum - (AW+1)'(CAPACITY);
		end
		return sum[AW-1:0];
	endfunction

	assign rd_addr = wrap_add(base, rd_off);
	assign wr_addr = wrap_add(base, wr_off);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### sv/ordered_list_engine_top.sv
`timescale 1ns / 1ps
// Top level of the ordered list engine: command sequencer, ring head and length, response register.
// Depends on ole_pkg and ole_store.

// The engine holds up to CAPACITY signed 32-bit values in a single ring memory and works on one
// command transaction at a time; cmd_stall is high from acceptance until the response has been
// handed to the response register, which can then hold it while the next command is taken.
// Find and erase walk the whole list through the single memory read port, one element a cycle.
// Insert at position P moves the N - P + 1 later elements of an N-element list back by one
// through the same port. Every command waits in its final state while an earlier response
// still waits on a stalled receiver.
module ordered_list_engine_top
	import ole_pkg::*;
#(
	parameter int CAPACITY = DEFAULT_CAPACITY
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_stall,
	input  cmd_t cmd,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int LW = $clog2(CAPACITY + 1);
	localparam int CW = (LW > POS_W) ? LW : POS_W;

	fsm_t               state_q, state_nxt;
	logic [LW-1:0]      len_q;
	logic [AW-1:0]      head_q;
	cmd_t               cmd_q;
	logic [AW-1:0]      rd_k_q;
	logic [LW-1:0]      wptr_q;
	logic               v_s1;
	logic [AW-1:0]      off_s1;
	status_t            status_q;
	logic [VALUE_W-1:0] popped_q;
	logic               found_q;
	logic [LW-1:0]      removed_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	logic               accept;
	logic               is_full;
	logic               is_empty;
	logic               pos_ok;
	logic [AW-1:0]      len_m1;
	logic [AW-1:0]      pos_m1;
	logic               last_read;
	logic               walk_ins;
	logic               keep_s1;
	logic               rsp_free;

	logic               rd_en;
	logic [AW-1:0]      rd_off;
	logic [VALUE_W-1:0] rd_data;
	logic               wr_en;
	logic [AW-1:0]      wr_off;
	logic [VALUE_W-1:0] wr_data;

	ole_store #(.CAPACITY(CAPACITY)) u_store (
		.clk    (clk),
		.base   (head_q),
		.rd_en  (rd_en),
		.rd_off (rd_off),
		.rd_data(rd_data),
		.wr_en  (wr_en),
		.wr_off (wr_off),
		.wr_data(wr_data)
	);

	assign cmd_stall = (state_q != S_IDLE);
	assign accept    = cmd_valid && (state_q == S_IDLE);
	assign is_full   = (len_q == LW'(CAPACITY));
	assign is_empty  = (len_q == '0);
	assign pos_ok    = (cmd.position != '0) && (CW'(cmd.position) <= CW'(len_q));
	assign len_m1    = AW'(len_q - 1'b1);
	assign pos_m1    = AW'(cmd_q.position - 1'b1);
	assign walk_ins  = (cmd_q.opcode == OP_INSERT);
	assign last_read = walk_ins ? (rd_k_q == pos_m1) : (rd_k_q == len_m1);
	assign keep_s1   = (rd_data != cmd_q.value);
	assign rsp_free  = !rsp_valid_q || !rsp_stall;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					case (cmd.opcode)
						OP_POP_FRONT, OP_POP_BACK: state_nxt = is_empty ? S_DONE : S_POP;
						OP_FIND, OP_ERASE:         state_nxt = is_empty ? S_DONE : S_WALK;
						OP_INSERT:                 state_nxt = (pos_ok && !is_full) ? S_WALK : S_DONE;
						default:                   state_nxt = S_DONE;
					endcase
				end
			end
			S_POP:   state_nxt = S_DONE;
			S_WALK:  state_nxt = last_read ? S_DRAIN : S_WALK;
			S_DRAIN: state_nxt = walk_ins ? S_PLACE : S_DONE;
			S_PLACE: state_nxt = S_DONE;
			S_DONE:  state_nxt = rsp_free ? S_IDLE : S_DONE;
			default: state_nxt = S_IDLE;
		endcase
	end

	// Memory port control. For insert and erase, the walk stages also write back the element read in the previous cycle.
	always_comb begin
		rd_en   = 1'b0;
		rd_off  = '0;
		wr_en   = 1'b0;
		wr_off  = '0;
		wr_data = rd_data;
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					case (cmd.opcode)
						OP_PUSH_FRONT: begin
							wr_en   = !is_full;
							wr_off  = AW'(CAPACITY - 1);
							wr_data = cmd.value;
						end
						OP_PUSH_BACK: begin
							wr_en   = !is_full;
							wr_off  = AW'(len_q);
							wr_data = cmd.value;
						end
						OP_POP_FRONT: begin
							rd_en  = !is_empty;
							rd_off = '0;
						end
						OP_POP_BACK: begin
							rd_en  = !is_empty;
							rd_off = len_m1;
						end
						default: begin
							rd_en = 1'b0;
						end
					endcase
				end
			end
			S_WALK, S_DRAIN: begin
				rd_en  = (state_q == S_WALK);
				rd_off = rd_k_q;
				if (v_s1) begin
					case (cmd_q.opcode)
						OP_INSERT: begin
							wr_en  = 1'b1;
							wr_off = off_s1 + 1'b1;
						end
						OP_ERASE: begin
							wr_en  = keep_s1;
							wr_off = AW'(wptr_q);
						end
						default: begin
							wr_en = 1'b0;
						end
					endcase
				end
			end
			S_PLACE: begin
				wr_en   = 1'b1;
				wr_off  = pos_m1;
				wr_data = cmd_q.value;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			len_q       <= '0;
			head_q      <= '0;
			v_s1        <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			v_s1    <= (state_q == S_WALK);
			if (accept) begin
				case (cmd.opcode)
					OP_PUSH_FRONT: begin
						if (!is_full) begin
							head_q <= (head_q == '0) ? AW'(CAPACITY - 1) : head_q - 1'b1;
							len_q  <= len_q + 1'b1;
						end
					end
					OP_PUSH_BACK: begin
						if (!is_full) begin
							len_q <= len_q + 1'b1;
						end
					end
					OP_POP_FRONT: begin
						if (!is_empty) begin
							head_q <= (head_q == AW'(CAPACITY - 1)) ? '0 : head_q + 1'b1;
							len_q  <= len_q - 1'b1;
						end
					end
					OP_POP_BACK: begin
						if (!is_empty) begin
							len_q <= len_q - 1'b1;
						end
					end
					default: begin
						len_q <= len_q;
					end
				endcase
			end
			if (state_q == S_DRAIN && cmd_q.opcode == OP_ERASE) begin
				len_q <= wptr_q + LW'(keep_s1);
			end
			if (state_q == S_PLACE) begin
				len_q <= len_q + 1'b1;
			end
			if (state_q == S_DONE && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q     <= cmd;
			popped_q  <= '0;
			found_q   <= 1'b0;
			removed_q <= '0;
			wptr_q    <= '0;
			rd_k_q    <= (cmd.opcode == OP_INSERT) ? len_m1 : '0;
			case (cmd.opcode)
				OP_PUSH_FRONT, OP_PUSH_BACK: begin
					status_q <= is_full ? ST_FULL : ST_OK;
				end
				OP_POP_FRONT, OP_POP_BACK: begin
					status_q <= is_empty ? ST_EMPTY : ST_OK;
				end
				OP_INSERT: begin
					// Position is checked before fullness.
					if (!pos_ok) begin
						status_q <= ST_BAD_POS;
					end else if (is_full) begin
						status_q <= ST_FULL;
					end else begin
						status_q <= ST_OK;
					end
				end
				default: begin
					status_q <= ST_OK;
				end
			endcase
		end
		if (state_q == S_POP) begin
			popped_q <= rd_data;
		end
		if (state_q == S_WALK) begin
			rd_k_q <= walk_ins ? rd_k_q - 1'b1 : rd_k_q + 1'b1;
			off_s1 <= rd_k_q;
		end
		if (v_s1) begin
			if (cmd_q.opcode == OP_FIND && !keep_s1) begin
				found_q <= 1'b1;
			end
			if (cmd_q.opcode == OP_ERASE && keep_s1) begin
				wptr_q <= wptr_q + 1'b1;
			end
		end
		if (state_q == S_DRAIN && cmd_q.opcode == OP_ERASE) begin
			removed_q <= len_q - (wptr_q + LW'(keep_s1));
		end
		if (state_q == S_DONE && rsp_free) begin
			rsp_q.status        <= status_q;
			rsp_q.popped_value  <= popped_q;
			rsp_q.found         <= found_q;
			rsp_q.removed_count <= COUNT_W'(removed_q);
			rsp_q.element_count <= COUNT_W'(len_q);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

### sv/ole_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the ordered list engine, attached to the top level by bind.
// Depends on ole_pkg.
module ole_checker
	import ole_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input logic cmd_stall,
	input cmd_t cmd,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	// A response held back by the receiver must not change.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response changed or dropped while stalled");

	// Every accepted command leaves the engine busy in the cycle after acceptance.
	a_busy_after_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> cmd_stall)
		else $error("command accepted back to back");

	// A new response only appears from the busy engine handing over a finished command.
	a_rsp_from_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(cmd_stall))
		else $error("response appeared without a command in progress");

	// A rejected command reports neither a popped value nor a found flag.
	a_popped_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_OK |-> rsp.popped_value == '0 && !rsp.found)
		else $error("rejected command reported data");

endmodule

bind ordered_list_engine_top ole_checker u_ole_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.cmd_valid(cmd_valid),
	.cmd_stall(cmd_stall),
	.cmd      (cmd),
	.rsp_valid(rsp_valid),
	.rsp_stall(rsp_stall),
	.rsp      (rsp)
);

### bench/tb_ordered_list_engine_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for ordered_list_engine_top: directed corner cases, then random runs.
// Depends on ole_pkg and the engine RTL; keeps its own copy of the list to predict every response.
module tb_ordered_list_engine_top;
	import ole_pkg::*;

	localparam int CAPACITY           = DEFAULT_CAPACITY;
	localparam int ITEMS_PER_PHASE    = 250;
	localparam int LONG_HOLD_CYCLES   = 400;
	localparam int QUIET_LIMIT        = 5000;
	localparam int END_SETTLE         = 100;
	localparam logic [2:0] OP_UNUSED  = 3'd7;
	localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'h7FFF_FFFF;
	localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'h8000_0000;

	typedef logic signed [VALUE_W-1:0] elem_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	cmd_t cmd = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	cmd_t  pending_commands[$];
	rsp_t  awaited_responses[$];
	elem_t held_values[$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int holds_requested = 0;
	int holds_served = 0;
	int hold_left = 0;
	int quiet_cycles = 0;
	int failures = 0;
	int queued_count = 0;
	int length_bound = 0;

	ordered_list_engine_top #(.CAPACITY(CAPACITY)) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Applies one command to the shadow list and returns the response it should produce.
	function automatic rsp_t apply_command(cmd_t c);
		rsp_t  r;
		elem_t kept[$];
		r = '0;
		r.status = ST_OK;
		case (c.opcode)
			OP_PUSH_FRONT, OP_PUSH_BACK: begin
				if (held_values.size() >= CAPACITY)
					r.status = ST_FULL;
				else if (c.opcode == OP_PUSH_FRONT)
					held_values.insert(0, c.value);
				else
					held_values.insert(held_values.size(), c.value);
			end
			OP_POP_FRONT, OP_POP_BACK: begin
				if (held_values.size() == 0) begin
					r.status = ST_EMPTY;
				end else if (c.opcode == OP_POP_FRONT) begin
					r.popped_value = held_values[0];
					held_values.delete(0);
				end else begin
					r.popped_value = held_values[held_values.size() - 1];
					held_values.delete(held_values.size() - 1);
				end
			end
			OP_FIND: begin
				foreach (held_values[i])
					if (held_values[i] == c.value)
						r.found = 1'b1;
			end
			OP_INSERT: begin
				// The position is judged before fullness.
				if (c.position == 0 || c.position > held_values.size())
					r.status = ST_BAD_POS;
				else if (held_values.size() >= CAPACITY)
					r.status = ST_FULL;
				else
					held_values.insert(int'(c.position) - 1, c.value);
			end
			OP_ERASE: begin
				foreach (held_values[i])
					if (held_values[i] != c.value)
						kept.insert(kept.size(), held_values[i]);
				r.removed_count = COUNT_W'(held_values.size() - kept.size());
				held_values = kept;
			end
			default: begin
			end
		endcase
		r.element_count = COUNT_W'(held_values.size());
		return r;
	endfunction

	task automatic check_response(rsp_t got);
		rsp_t want;
		if (awaited_responses.size() == 0) begin
			$error("response with no command outstanding: %h", got);
			failures++;
		end else begin
			want = awaited_responses[0];
			awaited_responses.delete(0);
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				failures++;
			end
			if (got.popped_value !== want.popped_value) begin
				$error("popped_value: expected %0d, got %0d", want.popped_value,
					got.popped_value);
				failures++;
			end
			if (got.found !== want.found) begin
				$error("found: expected %0d, got %0d", want.found, got.found);
				failures++;
			end
			if (got.removed_count !== want.removed_count) begin
				$error("removed_count: expected %0d, got %0d", want.removed_count,
					got.removed_count);
				failures++;
			end
			if (got.element_count !== want.element_count) begin
				$error("element_count: expected %0d, got %0d", want.element_count,
					got.element_count);
				failures++;
			end
		end
	endtask

	// Command side: predict on each accepted transaction, then offer the next one or idle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
			cmd <= '0;
		end else begin
			if (cmd_valid && !cmd_stall)
				awaited_responses.insert(awaited_responses.size(), apply_command(cmd));
			if (!cmd_valid || !cmd_stall) begin
				if (pending_commands.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					cmd_valid <= 1'b1;
					cmd <= pending_commands[0];
					pending_commands.delete(0);
				end else begin
					cmd_valid <= 1'b0;
				end
			end
		end
	end

	// Response side: check each accepted transaction and choose the stall for the next cycle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			hold_left <= 0;
			holds_served <= 0;
		end else begin
			if (rsp_valid && !rsp_stall)
				check_response(rsp);
			if (holds_served != holds_requested) begin
				holds_served <= holds_requested;
				hold_left <= LONG_HOLD_CYCLES;
				rsp_stall <= 1'b1;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	// length_bound never falls below the true length, since erase may shrink the list unseen.
	function automatic void add_cmd(opcode_t op, elem_t v, logic [POS_W-1:0] p);
		cmd_t c;
		c.opcode = op;
		c.value = v;
		c.position = p;
		pending_commands.insert(pending_commands.size(), c);
		queued_count++;
		case (op)
			OP_PUSH_FRONT, OP_PUSH_BACK:
				if (length_bound < CAPACITY) length_bound++;
			OP_POP_FRONT, OP_POP_BACK:
				if (length_bound > 0) length_bound--;
			OP_INSERT:
				if (p >= 1 && p <= length_bound && length_bound < CAPACITY) length_bound++;
			default: begin
			end
		endcase
	endfunction

	// Mostly a small pool so that finds hit and erases remove several elements.
	function automatic elem_t pick_value();
		case ($urandom_range(0, 9))
			6: return VALUE_MAX;
			7: return VALUE_MIN;
			8, 9: return elem_t'($urandom);
			default: return elem_t'($urandom_range(0, 7)) - 4;
		endcase
	endfunction

	function automatic opcode_t pick_push();
		return $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
	endfunction

	function automatic opcode_t pick_pop();
		return $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
	endfunction

	// Empties the list for certain, fills it past capacity, then tries insert, find and erase on the full store.
	task automatic queue_fill_cycle();
		int n;
		int k;
		n = length_bound + 2;
		for (k = 0; k < n; k++)
			add_cmd(pick_pop(), pick_value(), POS_W'($urandom_range(0, 64)));
		for (k = 0; k < CAPACITY + 2; k++)
			add_cmd(pick_push(), pick_value(), POS_W'($urandom_range(0, 64)));
		add_cmd(OP_INSERT, pick_value(), POS_W'($urandom_range(1, CAPACITY)));
		add_cmd(OP_FIND, pick_value(), '0);
		add_cmd(OP_ERASE, pick_value(), '0);
	endtask

	task automatic queue_mixed_run(int n);
		int k;
		int pick;
		logic [POS_W-1:0] p;
		for (k = 0; k < n; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				add_cmd(pick_push(), pick_value(), POS_W'($urandom_range(0, 64)));
			end else if (pick < 50) begin
				add_cmd(pick_pop(), pick_value(), POS_W'($urandom_range(0, 64)));
			end else if (pick < 62) begin
				add_cmd(OP_FIND, pick_value(), POS_W'($urandom_range(0, 64)));
			end else if (pick < 82) begin
				if ($urandom_range(0, 3) != 0 && length_bound > 0)
					p = POS_W'($urandom_range(1, length_bound));
				else
					p = POS_W'($urandom_range(0, 64));
				add_cmd(OP_INSERT, pick_value(), p);
			end else if (pick < 92) begin
				add_cmd(OP_ERASE, pick_value(), POS_W'($urandom_range(0, 64)));
			end else begin
				add_cmd(opcode_t'($urandom_range(0, 6)), elem_t'($urandom),
					POS_W'($urandom_range(0, 64)));
			end
		end
	endtask

	task automatic queue_random_phase(int target, bit start_with_fill);
		if (start_with_fill)
			queue_fill_cycle();
		while (queued_count < target) begin
			if ($urandom_range(0, 4) == 0)
				queue_fill_cycle();
			else
				queue_mixed_run($urandom_range(12, 24));
		end
	endtask

	task automatic wait_until_drained();
		while (pending_commands.size() != 0 || cmd_valid || awaited_responses.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_idle_pct = 9;
		recv_idle_pct = 74;
		// Corner cases on an empty list first, then a short list with both extreme values.
		add_cmd(OP_POP_FRONT, '0, '0);
		add_cmd(OP_POP_BACK, '0, '0);
		add_cmd(OP_INSERT, 5, POS_W'(1));
		add_cmd(OP_FIND, '0, '0);
		add_cmd(OP_ERASE, '0, '0);
		add_cmd(OP_PUSH_FRONT, VALUE_MAX, '0);
		add_cmd(OP_PUSH_BACK, VALUE_MIN, '0);
		add_cmd(OP_PUSH_FRONT, -1, '0);
		add_cmd(OP_PUSH_BACK, '0, '0);
		add_cmd(OP_FIND, VALUE_MIN, '0);
		add_cmd(OP_FIND, 5, '0);
		add_cmd(OP_INSERT, 9, '0);
		add_cmd(OP_INSERT, 9, POS_W'(5));
		add_cmd(OP_INSERT, 7, POS_W'(4));
		add_cmd(OP_INSERT, 7, POS_W'(1));
		add_cmd(OP_INSERT, 9, POS_W'(64));
		add_cmd(OP_PUSH_BACK, 7, '0);
		add_cmd(OP_ERASE, 7, '0);
		add_cmd(OP_POP_FRONT, '0, '0);
		add_cmd(OP_POP_BACK, '0, '0);
		add_cmd(opcode_t'(OP_UNUSED), -1, 7'd64);
		add_cmd(OP_FIND, 7, '0);
		add_cmd(OP_ERASE, VALUE_MAX, '0);
		queue_random_phase(ITEMS_PER_PHASE, 1'b1);
		wait_until_drained();

		send_idle_pct = 74;
		recv_idle_pct = 9;
		queue_random_phase(2 * ITEMS_PER_PHASE, 1'b0);
		wait_until_drained();

		// No idling here; a long hold on the response side lets the engine back up.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_random_phase(3 * ITEMS_PER_PHASE, 1'b0);
		holds_requested++;
		wait_until_drained();

		repeat (END_SETTLE) @(negedge clk);
		if (failures == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
